FILE: rtl/core/lzw_decode_dictionary_core_macros.svh
// ----------------------------------------------------------------------------
// LZW dictionary core assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef LZW_DECODE_DICTIONARY_CORE_MACROS_SVH
`define LZW_DECODE_DICTIONARY_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LZW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define LZW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lzw_dict_pkg.sv
// ----------------------------------------------------------------------------
// LZW dictionary package
// Sizes, codes and transaction payload types of the LZW dictionary core.
// ----------------------------------------------------------------------------
package lzw_dict_pkg;

  localparam int TABLE_SIZE      = 4096;
  localparam int FIRST_DICT_CODE = 256;
  localparam int CODE_W          = 12;
  localparam int BYTE_W          = 8;
  localparam int NEXT_W          = 13;
  localparam int ADDR_W          = $clog2(TABLE_SIZE);
  localparam int STEP_W          = $clog2(TABLE_SIZE + 1);
  localparam int LITERAL_MAX     = 255;

  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_INVALID  = 2'd2,
    STAT_BROKEN   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK
  } state_t;

  typedef struct packed {
    mode_t                    mode;
    logic [CODE_W-1:0]        code;
    logic [BYTE_W-1:0]        byte_req;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [NEXT_W-1:0]        next_code_out;
    logic                     present;
    logic [BYTE_W-1:0]        first_byte;
  } out_item_t;

endpackage

FILE: rtl/core/lzw_decode_dictionary_core.sv
// ----------------------------------------------------------------------------
// LZW decode dictionary core
// Dictionary store of an LZW decoder: appends entries at the next free code
// and walks prefix links of a looked-up code down to its first byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Payload
//   in_       input       in_valid/in_ready    in_data  (lzw_dict_pkg::in_item_t)
//   out_      output      out_valid/out_ready  out_data (lzw_dict_pkg::out_item_t)
//
// An append result is registered at the edge that accepts the transaction. A
// lookup is decided in the walk state; every prefix link followed costs a
// registered read of the entry memory and a pass through the link state that
// takes the fetched code, and a final result waits for a free output register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and the free
// code to the first dictionary code; there is no clearing pass, because an
// entry counts as filled exactly when its code lies below the free code.
// A stalled result holds in the output register; a new transaction is taken
// only when that register is empty or being drained in the same cycle.
module lzw_decode_dictionary_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lzw_dict_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lzw_dict_pkg::out_item_t out_data
);
  import lzw_dict_pkg::*;

  `include "lzw_decode_dictionary_core_macros.svh"

  localparam logic [NEXT_W-1:0] TABLE_N      = NEXT_W'(TABLE_SIZE);
  localparam logic [NEXT_W-1:0] FIRST_N      = NEXT_W'(FIRST_DICT_CODE);
  localparam logic [NEXT_W-1:0] LITERAL_N    = NEXT_W'(LITERAL_MAX);
  localparam logic [STEP_W-1:0] STEP_LIMIT   = STEP_W'(TABLE_SIZE);

  // Only the prefix link of each entry is ever read back, so the memory keeps
  // just that field. Validity follows from the free-code counter.
  logic [CODE_W-1:0] mem [TABLE_SIZE];
  logic [CODE_W-1:0] rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CODE_W-1:0] mem_wdata;

  state_t            state_r,     state_nxt;
  logic [NEXT_W-1:0] free_code_r, free_code_nxt;
  logic [CODE_W-1:0] code_r,      code_nxt;
  logic [STEP_W-1:0] steps_r,     steps_nxt;
  logic              present_r,   present_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r,  out_data_nxt;

  logic              out_free;
  logic              in_fire;
  logic [NEXT_W-1:0] in_code_w;
  logic [NEXT_W-1:0] cur_code_w;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign in_code_w  = {1'b0, in_data.code};
  assign cur_code_w = {1'b0, code_r};
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    free_code_nxt = free_code_r;
    code_nxt      = code_r;
    steps_nxt     = steps_r;
    present_nxt   = present_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = free_code_r[ADDR_W-1:0];
    mem_wdata     = in_data.code;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_data_nxt.present    = 1'b0;
          out_data_nxt.first_byte = '0;
          if (in_data.mode == MODE_APPEND) begin
            if (free_code_r >= TABLE_N) begin
              out_data_nxt.status = STAT_OVERFLOW;
            end else begin
              mem_we              = 1'b1;
              free_code_nxt       = free_code_r + NEXT_W'(1);
              out_data_nxt.status = STAT_OK;
            end
            out_data_nxt.next_code_out = free_code_nxt;
            out_valid_nxt              = 1'b1;
          end else begin
            // A code is present when it is a literal or lies in the filled range.
            present_nxt = (in_code_w < FIRST_N) || (in_code_w < free_code_r);
            if (in_code_w >= TABLE_N) begin
              out_data_nxt.status        = STAT_INVALID;
              out_data_nxt.next_code_out = free_code_r;
              out_data_nxt.present       = present_nxt;
              out_valid_nxt              = 1'b1;
            end else begin
              code_nxt  = in_data.code;
              steps_nxt = '0;
              state_nxt = ST_WALK;
            end
          end
        end
      end

      ST_WALK: begin
        // Decide on the current code; a final result waits for a free output.
        if (cur_code_w < FIRST_N) begin
          if (out_free) begin
            out_data_nxt.next_code_out = free_code_r;
            out_data_nxt.present       = present_r;
            if (cur_code_w > LITERAL_N) begin
              out_data_nxt.status     = STAT_INVALID;
              out_data_nxt.first_byte = '0;
            end else begin
              out_data_nxt.status     = STAT_OK;
              out_data_nxt.first_byte = code_r[BYTE_W-1:0];
            end
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (cur_code_w >= TABLE_N) begin
          if (out_free) begin
            out_data_nxt.status        = STAT_INVALID;
            out_data_nxt.next_code_out = free_code_r;
            out_data_nxt.present       = present_r;
            out_data_nxt.first_byte    = '0;
            out_valid_nxt              = 1'b1;
            state_nxt                  = ST_IDLE;
          end
        end else if ((cur_code_w >= free_code_r) || (steps_r == STEP_LIMIT)) begin
          // Empty entry, or a chain that loops back on itself.
          if (out_free) begin
            out_data_nxt.status        = STAT_BROKEN;
            out_data_nxt.next_code_out = free_code_r;
            out_data_nxt.present       = present_r;
            out_data_nxt.first_byte    = '0;
            out_valid_nxt              = 1'b1;
            state_nxt                  = ST_IDLE;
          end
        end else begin
          state_nxt = ST_LINK;
        end
      end

      ST_LINK: begin
        // The memory read issued during the walk cycle is now available.
        code_nxt  = rd_data_r;
        steps_nxt = steps_r + STEP_W'(1);
        state_nxt = ST_WALK;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_code_r <= FIRST_N;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_code_r <= free_code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    steps_r    <= steps_nxt;
    present_r  <= present_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[code_r[ADDR_W-1:0]];
  end

  `LZW_ASSERT_ALWAYS(a_free_code_range,
    (free_code_r >= FIRST_N) && (free_code_r <= TABLE_N),
    "free code left the dictionary range")

  `LZW_ASSERT_NEXT(a_append_advances,
    in_fire && (in_data.mode == MODE_APPEND) && (free_code_r < TABLE_N),
    (free_code_r == $past(free_code_r) + NEXT_W'(1)) && out_valid_r,
    "append did not advance the free code with a result")

  `LZW_ASSERT_NEXT(a_link_returns_to_walk,
    state_r == ST_LINK,
    (state_r == ST_WALK) && (steps_r <= STEP_LIMIT),
    "link fetch did not return to the walk within the step bound")

endmodule
